/* hdl/cptmr_pkg.sv */
// Shared types, operation codes and the prescaler table for the cascaded reload timers.
package cptmr_pkg;

    // Default timer count
    localparam int TIMER_COUNT_DEF = 4;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 16;
    localparam int IRQ_W   = 4;
    localparam int FIFO_W  = 2;
    localparam int PCNT_W  = 10;
    localparam int PSEL_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_CTRL   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // Control word bit positions
    localparam int CTRL_CU_BIT  = 2;
    localparam int CTRL_IRQ_BIT = 6;
    localparam int CTRL_EN_BIT  = 7;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    // Input beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  timer_index;
        logic [DATA_W-1:0] write_data;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_pulses;
        logic [FIFO_W-1:0] fifo_strobes;
    } t_out_beat;

    // Per-cell command from the top level
    typedef struct packed {
        logic              tick;
        logic              wr_reload;
        logic              wr_ctrl;
        logic [DATA_W-1:0] data;
    } t_cell_cmd;

    // Per-cell status towards the top level
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic              ovf;
        logic              irq;
    } t_cell_stat;

    // Prescale period: 1, 64, 256 or 1024 ticks
    function automatic logic [PCNT_W:0] prescale_period(input logic [PSEL_W-1:0] sel);
        logic [PCNT_W:0] period;
        case (sel)
            2'd0:    period = 11'd1;
            2'd1:    period = 11'd64;
            2'd2:    period = 11'd256;
            default: period = 11'd1024;
        endcase
        return period;
    endfunction

endpackage

/* hdl/cascaded_prescaled_reload_timers_core.sv */
// Top level of the cascaded prescaled reload timers: bus decode, cell chain and output register.
//
// A row of TIMER_COUNT 16-bit up-counting reload timers. Each accepted beat is either a clock
// tick or a bus access (reload write, control write, counter read) and yields exactly one
// result beat. One beat is accepted every cycle while the output stage is free or draining: the
// whole tick, including the overflow carry that ripples from each timer to the next through the
// cell chain, is combinational; a registered output stage holds the result, and a new beat can
// enter as the previous one is taken. The result appears in the cycle after acceptance. Timers
// are started by a control write with bit 7 set (bits 1:0 prescale, bit 2 count-up, bit 6 irq).
module cascaded_prescaled_reload_timers_core #(
    parameter int TIMER_COUNT = cptmr_pkg::TIMER_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cptmr_pkg::t_in_beat   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cptmr_pkg::t_out_beat  o_out_data
);

    logic                    r_out_valid;
    cptmr_pkg::t_out_beat    r_out, n_out;
    logic                    w_accept;

    cptmr_pkg::t_cell_cmd    w_cmd  [TIMER_COUNT];
    cptmr_pkg::t_cell_stat   w_stat [TIMER_COUNT];
    logic [TIMER_COUNT-1:0]  w_sel;

    // Handshake: take a beat whenever the output stage is free or draining
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;

    // Decode the bus access and build the cell chain
    for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
        assign w_sel[g] = (32'(i_in_data.timer_index) == g);

        assign w_cmd[g].tick      = w_accept & (i_in_data.op == cptmr_pkg::OP_TICK);
        assign w_cmd[g].wr_reload = w_accept & w_sel[g] & (i_in_data.op == cptmr_pkg::OP_RELOAD);
        assign w_cmd[g].wr_ctrl   = w_accept & w_sel[g] & (i_in_data.op == cptmr_pkg::OP_CTRL);
        assign w_cmd[g].data      = i_in_data.write_data;

        if (g == 0) begin : g_first
            cptmr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[g]),
                .i_carry (1'b0),
                .o_stat  (w_stat[g])
            );
        end else begin : g_rest
            cptmr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[g]),
                .i_carry (w_stat[g-1].ovf),
                .o_stat  (w_stat[g])
            );
        end
    end

    // Gather read data, interrupt pulses and FIFO strobes
    always_comb begin
        n_out = '0;
        for (int t = 0; t < TIMER_COUNT; t++) begin
            if (i_in_data.op == cptmr_pkg::OP_READ && w_sel[t]) begin
                n_out.read_data = w_stat[t].count;
            end
            if (t < cptmr_pkg::IRQ_W) begin
                n_out.irq_pulses[2'(t)] = w_stat[t].irq;
            end
            if (t < cptmr_pkg::FIFO_W) begin
                n_out.fifo_strobes[1'(t)] = w_stat[t].ovf;
            end
        end
    end

    // Output stage: hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A bus access never reports overflow activity
    a_bus_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.op != cptmr_pkg::OP_TICK)
        |=> (r_out.irq_pulses == '0 && r_out.fifo_strobes == '0))
        else $error("overflow activity reported on a bus access");

    // Read data is zero unless the beat was a read
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.op != cptmr_pkg::OP_READ) |=> (r_out.read_data == '0))
        else $error("read data nonzero on a non-read beat");

    // Every accepted beat produces a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat produced no result");

endmodule

/* hdl/cptmr_cell.sv */
// One timer cell: counter, reload, control bits and prescaler, with carry in from the cell below.
module cptmr_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cptmr_pkg::t_cell_cmd   i_cmd,
    input  logic                   i_carry,
    output cptmr_pkg::t_cell_stat  o_stat
);

    logic [cptmr_pkg::DATA_W-1:0] r_count, n_count;
    logic [cptmr_pkg::DATA_W-1:0] r_reload, n_reload;
    logic [cptmr_pkg::PSEL_W-1:0] r_psel, n_psel;
    logic                         r_cu, n_cu;
    logic                         r_irq_en, n_irq_en;
    logic                         r_running, n_running;
    logic [cptmr_pkg::PCNT_W-1:0] r_pcount, n_pcount;
    logic                         r_delay, n_delay;

    logic [cptmr_pkg::PCNT_W:0]   w_pnext;
    logic                         w_fire;
    logic                         w_advance;
    logic                         w_at_max;
    logic                         w_ovf;
    logic                         w_enable;

    // Prescaler compare and advance decision
    assign w_pnext   = {1'b0, r_pcount} + 11'd1;
    assign w_fire    = (w_pnext >= cptmr_pkg::prescale_period(r_psel));
    assign w_advance = r_running & (r_cu ? i_carry : (~r_delay & w_fire));
    assign w_at_max  = (r_count == cptmr_pkg::COUNT_MAX);
    assign w_ovf     = i_cmd.tick & w_advance & w_at_max;
    assign w_enable  = i_cmd.data[cptmr_pkg::CTRL_EN_BIT];

    // Next-state logic for tick, reload write and control write
    always_comb begin
        n_count   = r_count;
        n_reload  = r_reload;
        n_psel    = r_psel;
        n_cu      = r_cu;
        n_irq_en  = r_irq_en;
        n_running = r_running;
        n_pcount  = r_pcount;
        n_delay   = r_delay;
        if (i_cmd.tick) begin
            // advance prescaler, swallowing the first tick after start
            if (r_running && !r_cu) begin
                if (r_delay) begin
                    n_delay = 1'b0;
                end else if (w_fire) begin
                    n_pcount = '0;
                end else begin
                    n_pcount = w_pnext[cptmr_pkg::PCNT_W-1:0];
                end
            end
            if (w_advance) begin
                n_count = w_at_max ? r_reload : r_count + 16'd1;
            end
        end
        if (i_cmd.wr_reload) begin
            n_reload = i_cmd.data;
        end
        if (i_cmd.wr_ctrl) begin
            n_psel   = i_cmd.data[cptmr_pkg::PSEL_W-1:0];
            n_cu     = i_cmd.data[cptmr_pkg::CTRL_CU_BIT];
            n_irq_en = i_cmd.data[cptmr_pkg::CTRL_IRQ_BIT];
            if (w_enable && !r_running) begin
                n_count   = r_reload;
                n_pcount  = '0;
                n_delay   = ~i_cmd.data[cptmr_pkg::CTRL_CU_BIT];
                n_running = 1'b1;
            end else if (!w_enable && r_running) begin
                n_running = 1'b0;
                n_delay   = 1'b0;
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_reload  <= '0;
            r_psel    <= '0;
            r_cu      <= 1'b0;
            r_irq_en  <= 1'b0;
            r_running <= 1'b0;
            r_pcount  <= '0;
            r_delay   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_reload  <= n_reload;
            r_psel    <= n_psel;
            r_cu      <= n_cu;
            r_irq_en  <= n_irq_en;
            r_running <= n_running;
            r_pcount  <= n_pcount;
            r_delay   <= n_delay;
        end
    end

    // Report status
    assign o_stat.count = r_count;
    assign o_stat.ovf   = w_ovf;
    assign o_stat.irq   = w_ovf & r_irq_en;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the cascaded prescaled reload timers core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS = cptmr_pkg::TIMER_COUNT_DEF;
    localparam int PRESCALE_SHIFT[4] = '{0, 6, 8, 10};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_out_ready = 1'b0;
    cptmr_pkg::t_in_beat   i_in_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    cptmr_pkg::t_out_beat  o_out_data;

    // Idle percentages for each side and a long receiver hold-off
    int tx_idle_pct    = 32;
    int rx_idle_pct    = 81;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;

    // Results predicted for accepted beats, oldest first
    cptmr_pkg::t_out_beat timer_results_q[$];

    // Predicted timer state
    logic [cptmr_pkg::DATA_W-1:0] tmr_count  [NUM_TIMERS];
    logic [cptmr_pkg::DATA_W-1:0] tmr_reload [NUM_TIMERS];
    logic [cptmr_pkg::PSEL_W-1:0] tmr_psel   [NUM_TIMERS];
    logic                         tmr_cu     [NUM_TIMERS];
    logic                         tmr_irqen  [NUM_TIMERS];
    logic                         tmr_run    [NUM_TIMERS];
    logic [cptmr_pkg::PCNT_W-1:0] tmr_pcnt   [NUM_TIMERS];
    logic                         tmr_delay  [NUM_TIMERS];

    cascaded_prescaled_reload_timers_core #(
        .TIMER_COUNT(NUM_TIMERS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Advance the predicted timers by one beat and return the result it yields
    function automatic cptmr_pkg::t_out_beat predict_timers(input cptmr_pkg::t_in_beat beat);
        cptmr_pkg::t_out_beat res;
        int                   idx;
        int                   nxt;
        logic                 carry;
        logic                 adv;
        logic                 en;
        res   = '0;
        idx   = int'(beat.timer_index);
        carry = 1'b0;
        case (beat.op)
            cptmr_pkg::OP_TICK: begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    adv = 1'b0;
                    if (tmr_run[t]) begin
                        if (tmr_cu[t]) begin
                            adv = carry;
                        end else if (tmr_delay[t]) begin
                            // first tick after a start is swallowed
                            tmr_delay[t] = 1'b0;
                        end else begin
                            nxt = int'(tmr_pcnt[t]) + 1;
                            if (nxt >= (1 << PRESCALE_SHIFT[tmr_psel[t]])) begin
                                tmr_pcnt[t] = '0;
                                adv = 1'b1;
                            end else begin
                                tmr_pcnt[t] = nxt[cptmr_pkg::PCNT_W-1:0];
                            end
                        end
                    end
                    carry = 1'b0;
                    if (adv) begin
                        if (tmr_count[t] == cptmr_pkg::COUNT_MAX) begin
                            tmr_count[t] = tmr_reload[t];
                            if (tmr_irqen[t] && t < cptmr_pkg::IRQ_W)
                                res.irq_pulses[t] = 1'b1;
                            if (t < cptmr_pkg::FIFO_W) res.fifo_strobes[t] = 1'b1;
                            carry = 1'b1;
                        end else begin
                            tmr_count[t] = tmr_count[t] + 1'b1;
                        end
                    end
                end
            end
            cptmr_pkg::OP_RELOAD: begin
                if (idx < NUM_TIMERS) tmr_reload[idx] = beat.write_data;
            end
            cptmr_pkg::OP_CTRL: begin
                if (idx < NUM_TIMERS) begin
                    en              = beat.write_data[cptmr_pkg::CTRL_EN_BIT];
                    tmr_psel[idx]   = beat.write_data[cptmr_pkg::PSEL_W-1:0];
                    tmr_cu[idx]     = beat.write_data[cptmr_pkg::CTRL_CU_BIT];
                    tmr_irqen[idx]  = beat.write_data[cptmr_pkg::CTRL_IRQ_BIT];
                    if (en && !tmr_run[idx]) begin
                        tmr_count[idx] = tmr_reload[idx];
                        tmr_pcnt[idx]  = '0;
                        tmr_delay[idx] = !tmr_cu[idx];
                        tmr_run[idx]   = 1'b1;
                    end else if (!en && tmr_run[idx]) begin
                        tmr_run[idx]   = 1'b0;
                        tmr_delay[idx] = 1'b0;
                    end
                end
            end
            cptmr_pkg::OP_READ: begin
                if (idx < NUM_TIMERS) res.read_data = tmr_count[idx];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic cptmr_pkg::t_in_beat make_beat(input logic [cptmr_pkg::OP_W-1:0] op,
                                                      input int idx,
                                                      input logic [cptmr_pkg::DATA_W-1:0] data);
        cptmr_pkg::t_in_beat beat;
        beat.op          = op;
        beat.timer_index = idx[cptmr_pkg::IDX_W-1:0];
        beat.write_data  = data;
        return beat;
    endfunction

    function automatic logic [cptmr_pkg::DATA_W-1:0] ctrl_word(input int psel, input logic cu,
                                                               input logic irq, input logic en);
        logic [cptmr_pkg::DATA_W-1:0] w;
        w                          = '0;
        w[cptmr_pkg::PSEL_W-1:0]   = psel[cptmr_pkg::PSEL_W-1:0];
        w[cptmr_pkg::CTRL_CU_BIT]  = cu;
        w[cptmr_pkg::CTRL_IRQ_BIT] = irq;
        w[cptmr_pkg::CTRL_EN_BIT]  = en;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [cptmr_pkg::DATA_W-1:0] got,
                                   input logic [cptmr_pkg::DATA_W-1:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%04h, want 0x%04h", $realtime, what, got, want);
    endtask

    // Offer one beat, idling at random first, and predict its result on acceptance
    task automatic send_beat(input cptmr_pkg::t_in_beat beat);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        timer_results_q.push_back(predict_timers(beat));
    endtask

    task automatic tick_timers(input int n);
        repeat (n) send_beat(make_beat(cptmr_pkg::OP_TICK, $urandom_range(3),
                                       16'($urandom_range(16'hFFFF))));
    endtask

    // Hold the input quiet until every predicted result has been taken
    task automatic settle_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (timer_results_q.size() == 0);
    endtask

    // Receiver: random stalls, plus a counted hold-off when requested
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        cptmr_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (timer_results_q.size() == 0) begin
                report_mismatch("beat with nothing predicted", o_out_data.read_data, '0);
            end else begin
                want = timer_results_q.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_data.read_data, want.read_data);
                if (o_out_data.irq_pulses !== want.irq_pulses)
                    report_mismatch("irq_pulses", 16'(o_out_data.irq_pulses),
                                    16'(want.irq_pulses));
                if (o_out_data.fifo_strobes !== want.fifo_strobes)
                    report_mismatch("fifo_strobes", 16'(o_out_data.fifo_strobes),
                                    16'(want.fifo_strobes));
            end
        end
    end

    // Overflow with reload, interrupt, strobe and carry into a count-up timer
    task automatic test_overflow_cascade();
        send_beat(make_beat(cptmr_pkg::OP_READ, 0, 16'h0000));
        send_beat(make_beat(cptmr_pkg::OP_RELOAD, 0, 16'hFFFE));
        send_beat(make_beat(cptmr_pkg::OP_RELOAD, 1, 16'hFFFF));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 1, ctrl_word(0, 1'b1, 1'b1, 1'b1)));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(0, 1'b0, 1'b1, 1'b1)));
        // a read inside the start delay sees the reload value
        send_beat(make_beat(cptmr_pkg::OP_READ, 0, 16'h0000));
        tick_timers(3);
        send_beat(make_beat(cptmr_pkg::OP_READ, 1, 16'h0000));
    endtask

    // Stop captures the counter; count-up on timer 0 and on a stopped timer never moves
    task automatic test_stop_and_countup();
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(0, 1'b0, 1'b0, 1'b0)));
        tick_timers(1);
        send_beat(make_beat(cptmr_pkg::OP_READ, 0, 16'h0000));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(0, 1'b1, 1'b0, 1'b1)));
        tick_timers(2);
        send_beat(make_beat(cptmr_pkg::OP_READ, 0, 16'h0000));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 2, 16'hFF3F));
        tick_timers(1);
        send_beat(make_beat(cptmr_pkg::OP_READ, 2, 16'h0000));
    endtask

    // Control write on a running timer takes effect at once without a restart
    task automatic test_running_ctrl();
        send_beat(make_beat(cptmr_pkg::OP_RELOAD, 3, 16'h0000));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 3, 16'hFFFF));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 3, ctrl_word(0, 1'b0, 1'b0, 1'b1)));
        tick_timers(1);
        send_beat(make_beat(cptmr_pkg::OP_READ, 3, 16'h0000));
    endtask

    // Long runs with the slow prescalers, and a period cut below the running count
    task automatic test_slow_prescalers();
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(0, 1'b0, 1'b0, 1'b0)));
        for (int t = 0; t < NUM_TIMERS; t++) begin
            send_beat(make_beat(cptmr_pkg::OP_CTRL, t, ctrl_word(0, 1'b0, 1'b0, 1'b0)));
            send_beat(make_beat(cptmr_pkg::OP_RELOAD, t, 16'hFFFF));
        end
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(1, 1'b0, 1'b1, 1'b1)));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 1, ctrl_word(2, 1'b0, 1'b1, 1'b1)));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 2, ctrl_word(3, 1'b0, 1'b1, 1'b1)));
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 3, ctrl_word(0, 1'b1, 1'b1, 1'b1)));
        for (int n = 0; n < 530; n++) begin
            if (n == 250)
                send_beat(make_beat(cptmr_pkg::OP_CTRL, 1, ctrl_word(1, 1'b0, 1'b1, 1'b1)));
            if (n % 128 == 0)
                send_beat(make_beat(cptmr_pkg::OP_READ, $urandom_range(3), 16'h0000));
            tick_timers(1);
        end
        for (int t = 0; t < NUM_TIMERS; t++)
            send_beat(make_beat(cptmr_pkg::OP_READ, t, 16'h0000));
    endtask

    // Hold the receiver off while ticks keep coming, so the core stalls its input
    task automatic test_output_backpressure();
        send_beat(make_beat(cptmr_pkg::OP_CTRL, 0, ctrl_word(0, 1'b0, 1'b1, 1'b1)));
        rx_hold_cycles = 200;
        tick_timers(60);
        send_beat(make_beat(cptmr_pkg::OP_READ, 0, 16'h0000));
    endtask

    // Mostly setup sequences and tick bursts with random content, some reads and raw noise
    task automatic random_traffic(input int n_items);
        int                           sent;
        int                           kind;
        int                           idx;
        int                           burst;
        logic [cptmr_pkg::DATA_W-1:0] data;
        cptmr_pkg::t_in_beat          beat;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            idx  = $urandom_range(NUM_TIMERS - 1);
            if (kind < 45) begin
                burst = $urandom_range(1, 20);
                tick_timers(burst);
                sent += burst;
            end else if (kind < 70) begin
                data = ($urandom_range(1) == 1) ? {8'hFF, 8'($urandom)} : 16'($urandom);
                send_beat(make_beat(cptmr_pkg::OP_RELOAD, idx, data));
                data = 16'($urandom);
                data[cptmr_pkg::PSEL_W-1:0]  = ($urandom_range(99) < 60) ? 2'd0 : 2'($urandom);
                data[cptmr_pkg::CTRL_EN_BIT] = ($urandom_range(99) < 75);
                send_beat(make_beat(cptmr_pkg::OP_CTRL, idx, data));
                sent += 2;
            end else if (kind < 88) begin
                send_beat(make_beat(cptmr_pkg::OP_READ, idx, 16'($urandom)));
                sent++;
            end else begin
                beat.op          = 2'($urandom_range(3));
                beat.timer_index = 2'($urandom_range(3));
                beat.write_data  = 16'($urandom_range(16'hFFFF));
                send_beat(beat);
                sent++;
            end
        end
    endtask

    initial begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
            tmr_count[t]  = '0;
            tmr_reload[t] = '0;
            tmr_psel[t]   = '0;
            tmr_cu[t]     = 1'b0;
            tmr_irqen[t]  = 1'b0;
            tmr_run[t]    = 1'b0;
            tmr_pcnt[t]   = '0;
            tmr_delay[t]  = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 32;
        rx_idle_pct = 81;
        test_overflow_cascade();
        test_stop_and_countup();
        test_running_ctrl();
        random_traffic(60);
        settle_results();

        tx_idle_pct = 81;
        rx_idle_pct = 32;
        test_slow_prescalers();
        random_traffic(60);
        settle_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        settle_results();
        random_traffic(60);
        settle_results();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && timer_results_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/cptmr_pkg.sv
hdl/cptmr_cell.sv
hdl/cascaded_prescaled_reload_timers_core.sv
tb/testbench.sv
